// ===== sv/rhsh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsh_pkg
// Shared types and constants of the random hyperplane sign hash.
// ----------------------------------------------------------------------------
package rhsh_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Fixed field widths
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned ROW_FIELD_BITS = 8;
  localparam int unsigned COL_FIELD_BITS = 5;
  localparam int unsigned HASH_BITS = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 9;
  localparam int unsigned VLEN_BITS = 9;
  localparam int unsigned PCOUNT_BITS = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PROJECTION_COUNT = 2'd1;

  localparam logic [VLEN_BITS-1:0] VLEN_RESET = 9'd256;
  localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = 6'd32;

  // Depth of the queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH = 4;

endpackage

// ===== sv/rhsh_if.sv =====
// ----------------------------------------------------------------------------
// rhsh_if
// Valid/ready channel interfaces: input items, hash results, config writes.
// ----------------------------------------------------------------------------
interface rhsh_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [7:0]                  weight_row;
  logic [4:0]                  weight_col;
  logic signed [15:0]          weight_value;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (
    output valid, op, weight_row, weight_col, weight_value, sample_value,
    input  ready
  );
  modport sink (
    input  valid, op, weight_row, weight_col, weight_value, sample_value,
    output ready
  );
endinterface

interface rhsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_bits;

  modport source (output valid, hash_bits, input ready);
  modport sink (input valid, hash_bits, output ready);
endinterface

interface rhsh_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/rhsh_front.sv =====
// ----------------------------------------------------------------------------
// rhsh_front
// Accepts input items, drops out-of-range weight writes, tags each query
// element with its row and an end-of-query flag, and pushes commands.
// ----------------------------------------------------------------------------
module rhsh_front import rhsh_pkg::*; #(
  parameter int unsigned MAX_VECTOR_LENGTH = 256,
  parameter int unsigned MAX_PROJECTIONS   = 32,
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned CmdW              = 2 + 8 + 5 + 16 + 16,
  parameter int unsigned LenW              = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rhsh_in_if.sink             in_i,
  input  logic [LenW-1:0]     eff_len_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output logic [CmdW-1:0]     cmd_data_o
);

  localparam int unsigned RowW = $clog2(MAX_VECTOR_LENGTH);
  localparam int unsigned ColW = (MAX_PROJECTIONS > 1) ? $clog2(MAX_PROJECTIONS) : 1;
  localparam int unsigned CntW = ((LenW > RowW) ? LenW : RowW) + 1;

  typedef struct packed {
    op_e                           op;
    logic                          last;
    logic [RowW-1:0]               row;
    logic [ColW-1:0]               col;
    logic signed [WEIGHT_BITS-1:0] wval;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  logic [RowW-1:0] elem_q, elem_d;
  logic            is_query;
  logic            in_range;
  logic            last;
  logic            accept;
  cmd_t            cmd;

  assign is_query = (op_e'(in_i.op) == OP_QUERY);
  assign in_range = (32'(in_i.weight_row) < MAX_VECTOR_LENGTH) &&
                    (32'(in_i.weight_col) < MAX_PROJECTIONS);
  // current element closes the query, also when the length was lowered
  assign last     = (CntW'(elem_q) + CntW'(1)) >= CntW'(eff_len_i);

  assign in_i.ready  = cmd_ready_i;
  assign accept      = in_i.valid && cmd_ready_i;
  assign cmd_valid_o = in_i.valid && (is_query || in_range);

  always_comb begin
    cmd.op     = is_query ? OP_QUERY : OP_WRITE;
    cmd.last   = last;
    cmd.row    = is_query ? elem_q : RowW'(in_i.weight_row);
    cmd.col    = ColW'(in_i.weight_col);
    cmd.wval   = in_i.weight_value;
    cmd.sample = in_i.sample_value;
  end

  assign cmd_data_o = CmdW'(cmd);

  always_comb begin
    elem_d = elem_q;
    if (accept && is_query) begin
      elem_d = last ? '0 : elem_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
    end else begin
      elem_q <= elem_d;
    end
  end

endmodule

// ===== sv/rhsh_fifo.sv =====
// ----------------------------------------------------------------------------
// rhsh_fifo
// Small command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module rhsh_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== sv/rhsh_back.sv =====
// ----------------------------------------------------------------------------
// rhsh_back
// Weight store, per-projection multiply-accumulate lanes and hash output.
// Pipeline: row read -> products -> accumulate/sign -> output register.
// ----------------------------------------------------------------------------
module rhsh_back import rhsh_pkg::*; #(
  parameter int unsigned MAX_VECTOR_LENGTH = 256,
  parameter int unsigned MAX_PROJECTIONS   = 32,
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned CmdW              = 2 + 8 + 5 + 16 + 16,
  parameter int unsigned PcW               = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  logic [CmdW-1:0] cmd_data_i,
  input  logic [PcW-1:0]  eff_cnt_i,
  rhsh_out_if.source      out_o
);

  localparam int unsigned RowW  = $clog2(MAX_VECTOR_LENGTH);
  localparam int unsigned ColW  = (MAX_PROJECTIONS > 1) ? $clog2(MAX_PROJECTIONS) : 1;
  localparam int unsigned ProdW = SAMPLE_BITS + WEIGHT_BITS;
  localparam int unsigned AccW  = ProdW + RowW;
  localparam int unsigned HashN = (MAX_PROJECTIONS < HASH_BITS) ? MAX_PROJECTIONS : HASH_BITS;

  typedef struct packed {
    op_e                           op;
    logic                          last;
    logic [RowW-1:0]               row;
    logic [ColW-1:0]               col;
    logic signed [WEIGHT_BITS-1:0] wval;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  typedef logic [MAX_PROJECTIONS-1:0][WEIGHT_BITS-1:0] wrow_t;

  wrow_t                    weight_mem [MAX_VECTOR_LENGTH];
  wrow_t                    rd_q;
  cmd_t                     cmd;
  logic                     adv;
  logic                     s1_vld_q, s1_last_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                     s2_vld_q, s2_last_q;
  logic signed [ProdW-1:0]  prod_d [MAX_PROJECTIONS];
  logic signed [ProdW-1:0]  prod_q [MAX_PROJECTIONS];
  logic signed [AccW-1:0]   acc_d  [MAX_PROJECTIONS];
  logic signed [AccW-1:0]   acc_q  [MAX_PROJECTIONS];
  logic [HASH_BITS-1:0]     hash;
  logic                     out_vld_q;
  logic [HASH_BITS-1:0]     hash_q;

  assign cmd = cmd_t'(cmd_data_i);

  // whole back pipeline holds while a result waits unclaimed
  assign adv         = !out_vld_q || out_o.ready;
  assign cmd_ready_o = adv;

  // weight store: one word written or one full row read per cycle while the pipeline advances
  always_ff @(posedge clk_i) begin
    if (adv && cmd_valid_i && cmd.op == OP_WRITE) begin
      weight_mem[cmd.row][cmd.col] <= cmd.wval;
    end
    if (adv && cmd_valid_i && cmd.op == OP_QUERY) begin
      rd_q <= weight_mem[cmd.row];
    end
  end

  // lanes past the projection count contribute nothing
  always_comb begin
    for (int p = 0; p < MAX_PROJECTIONS; p++) begin
      if (PcW'(p) < eff_cnt_i) begin
        prod_d[p] = s1_sample_q * $signed(rd_q[p]);
      end else begin
        prod_d[p] = '0;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < MAX_PROJECTIONS; p++) begin
      acc_d[p] = acc_q[p] + AccW'(prod_q[p]);
    end
    hash = '0;
    for (int p = 0; p < HashN; p++) begin
      hash[p] = (PcW'(p) < eff_cnt_i) && !acc_d[p][AccW-1] && (acc_d[p] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sample_q <= cmd.sample;
      for (int p = 0; p < MAX_PROJECTIONS; p++) begin
        prod_q[p] <= prod_d[p];
      end
      if (s2_vld_q && s2_last_q) begin
        hash_q <= hash;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int p = 0; p < MAX_PROJECTIONS; p++) begin
        acc_q[p] <= '0;
      end
    end else begin
      if (adv) begin
        s1_vld_q  <= cmd_valid_i && (cmd.op == OP_QUERY);
        s1_last_q <= cmd.last;
        s2_vld_q  <= s1_vld_q;
        s2_last_q <= s1_last_q;
        if (s2_vld_q) begin
          for (int p = 0; p < MAX_PROJECTIONS; p++) begin
            acc_q[p] <= s2_last_q ? '0 : acc_d[p];
          end
        end
        out_vld_q <= s2_vld_q && s2_last_q;
      end
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.hash_bits = hash_q;

endmodule

// ===== sv/random_hyperplane_sign_hash.sv =====
// ----------------------------------------------------------------------------
// random_hyperplane_sign_hash
// Locality-sensitive sign hash over a loadable projection weight store.
// ----------------------------------------------------------------------------
// Weight writes and query elements share the input channel and are taken one
// per cycle while the four-entry command queue has room. The back end takes
// one command per cycle unless stalled, with a single weight store port that
// either writes one word or reads a whole row, and one pipelined multiplier
// per projection lane. Query results pass the row read and product registers
// into the output register. A result that is not taken stalls the back end;
// the front keeps filling the queue. Weights are undefined until written and
// there is no clearing pass after reset. Register 0 is vector_length, 1 is
// the hyperplane count; writes are only expected while the block is idle.
module random_hyperplane_sign_hash import rhsh_pkg::*; #(
  parameter int unsigned MAX_VECTOR_LENGTH = 256,
  parameter int unsigned MAX_PROJECTIONS   = 32,
  parameter int unsigned SAMPLE_BITS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhsh_cfg_if.sink    cfg_i,
  rhsh_in_if.sink     in_i,
  rhsh_out_if.source  out_o
);

  localparam int unsigned RowW = $clog2(MAX_VECTOR_LENGTH);
  localparam int unsigned ColW = (MAX_PROJECTIONS > 1) ? $clog2(MAX_PROJECTIONS) : 1;
  localparam int unsigned CmdW = 2 + RowW + ColW + WEIGHT_BITS + SAMPLE_BITS;
  localparam int unsigned LenW = $clog2(MAX_VECTOR_LENGTH + 1);
  localparam int unsigned PcW  = $clog2(MAX_PROJECTIONS + 1);

  logic [VLEN_BITS-1:0]   vlen_q;
  logic [PCOUNT_BITS-1:0] pcount_q;
  logic [LenW-1:0]        eff_len;
  logic [PcW-1:0]         eff_cnt;
  logic                   push_valid, push_ready;
  logic [CmdW-1:0]        push_data;
  logic                   pop_valid, pop_ready;
  logic [CmdW-1:0]        pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q   <= VLEN_RESET;
      pcount_q <= PCOUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VECTOR_LENGTH:    vlen_q   <= cfg_i.data[VLEN_BITS-1:0];
        CFG_PROJECTION_COUNT: pcount_q <= cfg_i.data[PCOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturate registers into their legal ranges
  always_comb begin
    if (vlen_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(vlen_q) > MAX_VECTOR_LENGTH) begin
      eff_len = LenW'(MAX_VECTOR_LENGTH);
    end else begin
      eff_len = LenW'(vlen_q);
    end
    if (pcount_q == '0) begin
      eff_cnt = PcW'(1);
    end else if (32'(pcount_q) > MAX_PROJECTIONS) begin
      eff_cnt = PcW'(MAX_PROJECTIONS);
    end else begin
      eff_cnt = PcW'(pcount_q);
    end
  end

  rhsh_front #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .MAX_PROJECTIONS   (MAX_PROJECTIONS),
    .SAMPLE_BITS       (SAMPLE_BITS),
    .CmdW              (CmdW),
    .LenW              (LenW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .eff_len_i   (eff_len),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_data_o  (push_data)
  );

  rhsh_fifo #(
    .Width (CmdW),
    .Depth (CMD_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rhsh_back #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .MAX_PROJECTIONS   (MAX_PROJECTIONS),
    .SAMPLE_BITS       (SAMPLE_BITS),
    .CmdW              (CmdW),
    .PcW               (PcW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_data_i  (pop_data),
    .eff_cnt_i   (eff_cnt),
    .out_o       (out_o)
  );

  // every accepted query element enters the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.op == OP_QUERY) |-> push_valid)
    else $error("query element transfer not queued");

  // out-of-range weight writes never reach the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.op == OP_WRITE &&
     ((32'(in_i.weight_row) >= MAX_VECTOR_LENGTH) ||
      (32'(in_i.weight_col) >= MAX_PROJECTIONS))) |-> !push_valid)
    else $error("out-of-range weight write queued");

  // back end holds its commands while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !pop_ready)
    else $error("command popped while result stalled");

  // a stalled result keeps its hash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(out_o.hash_bits))
    else $error("stalled hash changed");

endmodule

// ===== sim/random_hyperplane_sign_hash_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_hyperplane_sign_hash_test
// Self-checking bench for the sign hash. It fills the weight rows that the
// queries read, walks a directed table (extremes, register saturation,
// mid-query changes), then streams random queries under many register
// settings while both channels idle at random. Every hash is checked against
// a table value or a bench model of the multiply-accumulate and sign stage.
// ----------------------------------------------------------------------------
module random_hyperplane_sign_hash_test;
  import rhsh_pkg::*;

  localparam int unsigned MAX_VLEN      = 256;
  localparam int unsigned MAX_PROJ      = 32;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned FILL_ROWS     = 12;
  localparam int unsigned ABOVE_ELEMS   = 6;
  localparam int unsigned RANDOM_ITEMS  = 220;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES  = 100000;
  localparam int unsigned DIR_STEPS     = 26;
  localparam int unsigned MAX_REPORTS   = 50;

  typedef struct packed {
    op_e                       op;
    logic [ROW_FIELD_BITS-1:0] row;
    logic [COL_FIELD_BITS-1:0] col;
    logic [WEIGHT_BITS-1:0]    weight;
    logic [SAMPLE_W-1:0]       sample;
  } hash_item_t;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_WRITE,
    STEP_QUERY
  } step_kind_e;

  // value is the weight of a write or the sample of a query
  typedef struct packed {
    step_kind_e                kind;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic [ROW_FIELD_BITS-1:0] row;
    logic [COL_FIELD_BITS-1:0] col;
    logic [15:0]               value;
    logic                      known;
    logic [HASH_BITS-1:0]      hash;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rhsh_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  rhsh_out_if out_if ();
  rhsh_cfg_if cfg_if ();

  random_hyperplane_sign_hash #(
    .MAX_VECTOR_LENGTH(MAX_VLEN),
    .MAX_PROJECTIONS  (MAX_PROJ),
    .SAMPLE_BITS      (SAMPLE_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state
  logic signed [WEIGHT_BITS-1:0] weight_mem [MAX_VLEN][MAX_PROJ];
  longint                        proj_sum [MAX_PROJ];
  int unsigned                   elem_idx;
  logic [VLEN_BITS-1:0]          vlen_reg;
  logic [PCOUNT_BITS-1:0]        pcount_reg;
  logic [HASH_BITS-1:0]          hash_q [$];
  logic [HASH_BITS-1:0]          want_hash;

  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned cycle_cnt;
  int unsigned ready_mode;
  int unsigned ready_left;

  // Directed table: row 0 columns 0..2 hold max, min and zero weights, so
  // with one element per query the hash is just the sign pattern.
  step_t dir_steps [DIR_STEPS] = '{
    '{STEP_CFG,   CFG_VECTOR_LENGTH,    9'd1,  8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_CFG,   CFG_PROJECTION_COUNT, 9'd3,  8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_WRITE, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h7FFF, 1'b0, 32'h0},
    '{STEP_WRITE, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd1,  16'h8000, 1'b0, 32'h0},
    '{STEP_WRITE, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd2,  16'h0000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h7FFF, 1'b1, 32'h1},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h8000, 1'b1, 32'h2},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h0000, 1'b1, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h0001, 1'b1, 32'h1},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'hFFFF, 1'b1, 32'h2},
    // zero length saturates to one element
    '{STEP_CFG,   CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h0005, 1'b1, 32'h1},
    // zero count saturates to one projection
    '{STEP_CFG,   CFG_PROJECTION_COUNT, 9'd0,  8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'hFFF9, 1'b1, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h0007, 1'b1, 32'h1},
    '{STEP_CFG,   CFG_PROJECTION_COUNT, 9'd63, 8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_CFG,   CFG_VECTOR_LENGTH,    9'd4,  8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h1234, 1'b0, 32'h0},
    // weight rewritten mid-query, used by the very next element
    '{STEP_WRITE, CFG_VECTOR_LENGTH,    9'd0,  8'd1,   5'd7,  16'h8000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h8000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h7FFF, 1'b0, 32'h0},
    // length dropped below the running index: next element closes the query
    '{STEP_CFG,   CFG_VECTOR_LENGTH,    9'd2,  8'd0,   5'd0,  16'h0000, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h4321, 1'b0, 32'h0},
    '{STEP_WRITE, CFG_VECTOR_LENGTH,    9'd0,  8'hFF,  5'h1F, 16'h7FFF, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h7FFF, 1'b0, 32'h0},
    '{STEP_QUERY, CFG_VECTOR_LENGTH,    9'd0,  8'd0,   5'd0,  16'h8000, 1'b0, 32'h0}
  };

  // Applies one accepted item; returns 1 when it closes a query.
  function automatic bit hash_step(input hash_item_t item,
                                   output logic [HASH_BITS-1:0] hash);
    int unsigned len;
    int unsigned cnt;
    int unsigned p;
    hash = '0;
    len = (vlen_reg == 0) ? 1 : (vlen_reg > MAX_VLEN) ? MAX_VLEN : vlen_reg;
    cnt = (pcount_reg == 0) ? 1 : (pcount_reg > MAX_PROJ) ? MAX_PROJ : pcount_reg;
    if (item.op == OP_WRITE) begin
      weight_mem[item.row][item.col] = item.weight;
      return 1'b0;
    end
    for (p = 0; p < cnt; p++) begin
      proj_sum[p] += longint'($signed(item.sample)) * longint'(weight_mem[elem_idx][p]);
    end
    if (elem_idx + 1 >= len) begin
      for (p = 0; p < cnt; p++) begin
        hash[p] = (proj_sum[p] > 0);
      end
      proj_sum = '{default: 0};
      elem_idx = 0;
      return 1'b1;
    end
    elem_idx++;
    return 1'b0;
  endfunction

  function automatic logic [15:0] rand_word();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return rnd[15:0];
    endcase
  endfunction

  function automatic hash_item_t make_item(input op_e op);
    hash_item_t  item;
    logic [31:0] rnd;
    rnd = $urandom;
    item.op     = op;
    item.row    = rnd[7:0];
    item.col    = rnd[12:8];
    item.weight = rand_word();
    item.sample = rand_word();
    return item;
  endfunction

  task automatic report_mismatch(input string what, input logic [HASH_BITS-1:0] got,
                                 input logic [HASH_BITS-1:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic send_item(input hash_item_t item, input logic known,
                           input logic [HASH_BITS-1:0] known_hash);
    int unsigned          gap;
    logic [HASH_BITS-1:0] hash;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.op           <= item.op;
    in_if.weight_row   <= item.row;
    in_if.weight_col   <= item.col;
    in_if.weight_value <= item.weight;
    in_if.sample_value <= item.sample;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // transfer at this edge; valid stays up for a back-to-back item
    if (hash_step(item, hash)) hash_q.push_back(known ? known_hash : hash);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data, input logic last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (last) cfg_if.valid <= 1'b0;
    case (index)
      CFG_VECTOR_LENGTH:    vlen_reg = data[VLEN_BITS-1:0];
      CFG_PROJECTION_COUNT: pcount_reg = data[PCOUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes and unfinished query elements give no result, so after the last
  // hash the back end may still be busy.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (hash_q.size() == 0) begin
        report_mismatch("hash with none pending", out_if.hash_bits, '0);
      end else begin
        want_hash = hash_q.pop_front();
        if (out_if.hash_bits !== want_hash) begin
          report_mismatch("hash_bits", out_if.hash_bits, want_hash);
        end
      end
    end
  end

  // Receiver: switches between always-ready, coin-flip, ready when its phase
  // counter is a multiple of four, and long stalls.
  initial begin
    out_if.ready <= 1'b0;
    ready_mode = 0;
    ready_left = 0;
    forever begin
      @(posedge clk_i);
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(8, 80);
      end
      ready_left--;
      case (ready_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) == 1);
        2:       out_if.ready <= (ready_left % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TIMEOUT after %0d cycles", cycle_cnt);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    hash_item_t                item;
    step_t                     step;
    int unsigned               row;
    int unsigned               col;
    int unsigned               s;
    int unsigned               n;
    int unsigned               sent;
    logic [31:0]               rnd;
    logic [CFG_DATA_BITS-1:0]  vl;
    logic [CFG_DATA_BITS-1:0]  pc;

    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.op           <= OP_WRITE;
    in_if.weight_row   <= '0;
    in_if.weight_col   <= '0;
    in_if.weight_value <= '0;
    in_if.sample_value <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    vlen_reg   = VLEN_RESET;
    pcount_reg = PCOUNT_RESET;
    elem_idx   = 0;
    proj_sum   = '{default: 0};
    mismatches = 0;
    burst_left = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Weights are undefined until written: fill every row a query reaches.
    for (row = 0; row < FILL_ROWS; row++) begin
      for (col = 0; col < MAX_PROJ; col++) begin
        item     = make_item(OP_WRITE);
        item.row = row[ROW_FIELD_BITS-1:0];
        item.col = col[COL_FIELD_BITS-1:0];
        send_item(item, 1'b0, '0);
      end
    end

    for (s = 0; s < DIR_STEPS; s++) begin
      step = dir_steps[s];
      if (step.kind == STEP_CFG) begin
        settle_idle();
        write_reg(step.cfg_index, step.cfg_data, 1'b1);
      end else begin
        item = make_item((step.kind == STEP_WRITE) ? OP_WRITE : OP_QUERY);
        if (step.kind == STEP_WRITE) begin
          item.row    = step.row;
          item.col    = step.col;
          item.weight = step.value;
        end else begin
          item.sample = step.value;
        end
        send_item(item, step.known, step.hash);
      end
    end

    // Both registers above range: the query must not close early; a lowered
    // length then closes it on the next element.
    settle_idle();
    write_reg(CFG_VECTOR_LENGTH, 9'h1FF, 1'b0);
    write_reg(CFG_PROJECTION_COUNT, 9'd63, 1'b1);
    for (n = 0; n < ABOVE_ELEMS; n++) begin
      send_item(make_item(OP_QUERY), 1'b0, '0);
    end
    settle_idle();
    write_reg(CFG_VECTOR_LENGTH, 9'd2, 1'b1);
    send_item(make_item(OP_QUERY), 1'b0, '0);
    sent = 0;

    // Short queries with weight writes mixed in; a phase may end mid-query.
    while (sent < RANDOM_ITEMS) begin
      settle_idle();
      case ($urandom_range(0, 7))
        0: vl = 9'd0;
        1: vl = 9'd1;
        default: begin
          rnd = $urandom_range(2, FILL_ROWS);
          vl  = rnd[CFG_DATA_BITS-1:0];
        end
      endcase
      case ($urandom_range(0, 7))
        0: pc = 9'd0;
        1: pc = 9'd63;
        2: pc = 9'd32;
        3: pc = 9'd1;
        default: begin
          rnd = $urandom_range(2, 40);
          pc  = rnd[CFG_DATA_BITS-1:0];
        end
      endcase
      write_reg(CFG_VECTOR_LENGTH, vl, 1'b0);
      write_reg(CFG_PROJECTION_COUNT, pc, 1'b1);
      n = $urandom_range(20, 50);
      repeat (n) begin
        item = make_item(($urandom_range(0, 6) == 0) ? OP_WRITE : OP_QUERY);
        send_item(item, 1'b0, '0);
      end
      sent += n;
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
